// File: rtl/rttb_pkg.sv
`timescale 1ns / 1ps

package rttb_pkg;

	// Configuration register indexes.
	localparam logic [2:0] CFG_ENABLE     = 3'd0;
	localparam logic [2:0] CFG_WARMUP     = 3'd1;
	localparam logic [2:0] CFG_FLOOR_SCL  = 3'd2;
	localparam logic [2:0] CFG_FLOOR_LOW  = 3'd3;
	localparam logic [2:0] CFG_FLOOR_HIGH = 3'd4;
	localparam logic [2:0] CFG_CAP_NORM   = 3'd5;
	localparam logic [2:0] CFG_CAP_CONG   = 3'd6;
	localparam logic [2:0] CFG_QRATIO     = 3'd7;

	// Reset values of the configuration registers.
	localparam logic [15:0] RST_FLOOR_SCL  = 16'd1000;
	localparam logic [19:0] RST_FLOOR_HIGH = 20'd200000;

	// Default of the build-time floor ceiling, in microseconds.
	localparam int FLOOR_CAP_US_DEF = 200000;

	// Cap limits, in milliseconds, and the default queueing ratio.
	localparam logic [16:0] CAP_MIN_MS    = 17'd1000;
	localparam logic [16:0] CAP_MAX_MS    = 17'd120000;
	localparam logic [15:0] DEFAULT_RATIO = 16'd2000;

	// Product thresholds for the cap clamp: below 1000 ms and above 120000 ms.
	localparam logic [47:0] CAP_LO_PROD = 48'd1000000000;
	localparam logic [47:0] CAP_HI_PROD = 48'd120001000000;

	// Reciprocals for exact division by a constant: q = (x * M) >> S, valid
	// for every x below 2**N, with M = ceil(2**(N + L) / d).
	localparam int          DIV125_HI_SHIFT = 28;
	localparam logic [21:0] DIV125_HI_RCP   =
		22'(((64'd1 << DIV125_HI_SHIFT) + 64'd124) / 64'd125);
	localparam int          DIV125_LO_SHIFT = 38;
	localparam logic [31:0] DIV125_LO_RCP   =
		32'(((64'd1 << DIV125_LO_SHIFT) + 64'd124) / 64'd125);
	localparam int          DIV15625_SHIFT  = 45;
	localparam logic [31:0] DIV15625_RCP    =
		32'(((64'd1 << DIV15625_SHIFT) + 64'd15624) / 64'd15625);

	// Outcome codes of a bound update.
	typedef logic [2:0] outcome_t;
	localparam outcome_t OUT_NONE          = 3'd0;
	localparam outcome_t OUT_UNCHANGED     = 3'd1;
	localparam outcome_t OUT_APPLIED       = 3'd2;
	localparam outcome_t OUT_REJECTED      = 3'd3;
	localparam outcome_t OUT_CONTRADICTORY = 3'd4;
	localparam outcome_t OUT_DEFAULT       = 3'd4;

	// Per-sample control that travels down the pipeline.
	typedef struct packed {
		logic        func;
		logic        base_nz;
		logic        floor_ok;
		logic        cap_ok;
		logic [31:0] ce;
	} ctl_t;

endpackage

// File: rtl/rtt_timeout_bound_tuner_unit.sv
// Retransmit-timeout bound tuner for one flow. Each input word is either a
// new-flow command (func 0, clears the per-flow state) or an RTT sample
// (func 1) that yields exactly one result word: a request for default
// bounds when tuning is disabled, a warmup skip, or the minimum timeout
// (floor, microseconds) and maximum timeout (cap, milliseconds) derived from
// the larger of the smoothed and the minimum RTT. A bound is written only
// when it differs from the value last applied, and a write that the stack
// rejects leaves the state as it was. The unit is a six-register pipeline
// that takes one word in every cycle while the output is not stalled; the
// depth comes from the exact divisions by 1000 and by 1000000, which are
// done as reciprocal multiplications split over three stages. Only the
// last stage reads and updates the per-flow state, so back to back samples
// of the same flow see each other's updates. Empty stages close up while
// the output is stalled, so input is taken until the pipeline is full.
// Configuration writes are always ready and must be made while no sample
// is in flight.
`timescale 1ns / 1ps

module rtt_timeout_bound_tuner_unit #(
	parameter int FLOOR_CAP_US = rttb_pkg::FLOOR_CAP_US_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [31:0] srtt_scaled,
	input  logic [31:0] min_rtt_in,
	input  logic [31:0] ce_count,
	input  logic        floor_accepted,
	input  logic        cap_accepted,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        unsubscribe,
	output logic        floor_write,
	output logic [17:0] floor_value_us,
	output logic [2:0]  floor_outcome,
	output logic        cap_write,
	output logic [16:0] cap_value_ms,
	output logic [2:0]  cap_outcome,
	output logic        congested,
	output logic        warmup_skip
);

	// Width of an applied floor: it never exceeds the build-time ceiling.
	localparam int FloorW = $clog2(FLOOR_CAP_US + 1);
	localparam logic [19:0] CapUs = 20'(FLOOR_CAP_US);

	// ------------------------------------------------------------------
	// Configuration registers. The port never pushes back.
	// ------------------------------------------------------------------
	logic        cfg_enable_q;
	logic [15:0] cfg_warmup_q;
	logic [15:0] cfg_floor_scl_q;
	logic [19:0] cfg_floor_low_q;
	logic [19:0] cfg_floor_high_q;
	logic [15:0] cfg_cap_norm_q;
	logic [15:0] cfg_cap_cong_q;
	logic [15:0] cfg_qratio_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_enable_q     <= 1'b0;
			cfg_warmup_q     <= 16'd0;
			cfg_floor_scl_q  <= rttb_pkg::RST_FLOOR_SCL;
			cfg_floor_low_q  <= 20'd0;
			cfg_floor_high_q <= rttb_pkg::RST_FLOOR_HIGH;
			cfg_cap_norm_q   <= 16'd0;
			cfg_cap_cong_q   <= 16'd0;
			cfg_qratio_q     <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rttb_pkg::CFG_ENABLE:     cfg_enable_q     <= cfg_data[0];
				rttb_pkg::CFG_WARMUP:     cfg_warmup_q     <= cfg_data[15:0];
				rttb_pkg::CFG_FLOOR_SCL:  cfg_floor_scl_q  <= cfg_data[15:0];
				rttb_pkg::CFG_FLOOR_LOW:  cfg_floor_low_q  <= cfg_data[19:0];
				rttb_pkg::CFG_FLOOR_HIGH: cfg_floor_high_q <= cfg_data[19:0];
				rttb_pkg::CFG_CAP_NORM:   cfg_cap_norm_q   <= cfg_data[15:0];
				rttb_pkg::CFG_CAP_CONG:   cfg_cap_cong_q   <= cfg_data[15:0];
				rttb_pkg::CFG_QRATIO:     cfg_qratio_q     <= cfg_data[15:0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Flow control. A stage loads when it is empty or its word moves on,
	// so bubbles are squeezed out while the output is stalled.
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, out_valid_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_out;
	logic retire;

	assign ld_out = !out_valid_q || !out_stall;
	assign ld_s5  = !vld_s5 || ld_out;
	assign ld_s4  = !vld_s4 || ld_s5;
	assign ld_s3  = !vld_s3 || ld_s4;
	assign ld_s2  = !vld_s2 || ld_s3;
	assign ld_s1  = !vld_s1 || ld_s2;
	assign retire = vld_s5 && ld_out;

	assign in_stall  = !ld_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1)  vld_s1      <= in_valid;
			if (ld_s2)  vld_s2      <= vld_s1;
			if (ld_s3)  vld_s3      <= vld_s2;
			if (ld_s4)  vld_s4      <= vld_s3;
			if (ld_s5)  vld_s5      <= vld_s4;
			if (ld_out) out_valid_q <= vld_s5;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: input register.
	// ------------------------------------------------------------------
	logic        func_s1, floor_ok_s1, cap_ok_s1;
	logic [31:0] srtt_scaled_s1, min_rtt_s1, ce_s1;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			func_s1        <= func;
			srtt_scaled_s1 <= srtt_scaled;
			min_rtt_s1     <= min_rtt_in;
			ce_s1          <= ce_count;
			floor_ok_s1    <= floor_accepted;
			cap_ok_s1      <= cap_accepted;
		end
	end

	// Base RTT and the raw products. An unknown minimum RTT reads as zero.
	logic [28:0] srtt_us;
	logic [31:0] mrtt_us, base_us;
	logic [15:0] ratio;

	assign srtt_us = srtt_scaled_s1[31:3];
	assign mrtt_us = (min_rtt_s1 == '1) ? 32'd0 : min_rtt_s1;
	assign base_us = ({3'b0, srtt_us} > mrtt_us) ? {3'b0, srtt_us} : mrtt_us;
	assign ratio   = (cfg_qratio_q != 16'd0) ? cfg_qratio_q : rttb_pkg::DEFAULT_RATIO;

	// ------------------------------------------------------------------
	// Stage 2: products of base with the three permille scales, and the two
	// sides of the queueing test.
	// ------------------------------------------------------------------
	rttb_pkg::ctl_t ctl_s2;
	logic [47:0]    floor_prod_s2, capn_prod_s2, capc_prod_s2;
	logic [47:0]    srtt_k_s2, mrtt_k_s2;
	logic           mrtt_nz_s2;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			ctl_s2.func     <= func_s1;
			ctl_s2.base_nz  <= (base_us != 32'd0);
			ctl_s2.floor_ok <= floor_ok_s1;
			ctl_s2.cap_ok   <= cap_ok_s1;
			ctl_s2.ce       <= ce_s1;
			floor_prod_s2   <= 48'(base_us) * 48'(cfg_floor_scl_q);
			capn_prod_s2    <= 48'(base_us) * 48'(cfg_cap_norm_q);
			capc_prod_s2    <= 48'(base_us) * 48'(cfg_cap_cong_q);
			srtt_k_s2       <= 48'(srtt_us) * 48'd1000;
			mrtt_k_s2       <= 48'(mrtt_us) * 48'(ratio);
			mrtt_nz_s2      <= (mrtt_us != 32'd0);
		end
	end

	// Floor quotient: prod / 1000 = (prod >> 3) / 125. The 45-bit dividend
	// is split into a high part and a 24-bit low part; the high part is
	// divided first and its remainder joins the low part.
	logic [20:0] fl_hi;
	logic [42:0] fl_hi_prod;

	assign fl_hi      = floor_prod_s2[47:27];
	assign fl_hi_prod = 43'(fl_hi) * 43'(rttb_pkg::DIV125_HI_RCP);

	// Cap quotient: prod / 1000000, clamped to the cap range. Inside the
	// range the product is below 2**37, so (prod >> 6) / 15625 fits 31 bits.
	function automatic logic [16:0] cap_clamp(input logic [47:0] prod);
		logic [62:0] q;
		q = 63'(prod[36:6]) * 63'(rttb_pkg::DIV15625_RCP);
		if (prod < rttb_pkg::CAP_LO_PROD)
			return rttb_pkg::CAP_MIN_MS;
		else if (prod >= rttb_pkg::CAP_HI_PROD)
			return rttb_pkg::CAP_MAX_MS;
		else
			return q[rttb_pkg::DIV15625_SHIFT +: 17];
	endfunction

	// ------------------------------------------------------------------
	// Stage 3: high floor quotient, both clamped cap targets, queueing.
	// ------------------------------------------------------------------
	rttb_pkg::ctl_t ctl_s3;
	logic [14:0]    fl_qhi_s3;
	logic [20:0]    fl_hi_s3;
	logic [23:0]    fl_lo_s3;
	logic [16:0]    capn_s3, capc_s3;
	logic           queue_s3;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			ctl_s3    <= ctl_s2;
			fl_qhi_s3 <= fl_hi_prod[rttb_pkg::DIV125_HI_SHIFT +: 15];
			fl_hi_s3  <= fl_hi;
			fl_lo_s3  <= floor_prod_s2[26:3];
			capn_s3   <= cap_clamp(capn_prod_s2);
			capc_s3   <= cap_clamp(capc_prod_s2);
			queue_s3  <= mrtt_nz_s2 && (srtt_k_s2 > mrtt_k_s2);
		end
	end

	logic [20:0] fl_rem_full;

	assign fl_rem_full = fl_hi_s3 - 21'(fl_qhi_s3) * 21'd125;

	// ------------------------------------------------------------------
	// Stage 4: remainder of the high part. Only the low byte of the high
	// quotient survives the 32-bit truncation of the floor target.
	// ------------------------------------------------------------------
	rttb_pkg::ctl_t ctl_s4;
	logic [7:0]     fl_qhi_s4;
	logic [6:0]     fl_rem_s4;
	logic [23:0]    fl_lo_s4;
	logic [16:0]    capn_s4, capc_s4;
	logic           queue_s4;

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			ctl_s4    <= ctl_s3;
			fl_qhi_s4 <= fl_qhi_s3[7:0];
			fl_rem_s4 <= fl_rem_full[6:0];
			fl_lo_s4  <= fl_lo_s3;
			capn_s4   <= capn_s3;
			capc_s4   <= capc_s3;
			queue_s4  <= queue_s3;
		end
	end

	// The joined dividend is below 125 * 2**24, so its quotient has 24 bits.
	logic [62:0] fl_lo_prod;
	logic [31:0] floor_t32;
	logic [19:0] ceil_us;
	logic        floor_contra;
	logic [FloorW-1:0] floor_tgt;

	assign fl_lo_prod   = 63'({fl_rem_s4, fl_lo_s4}) * 63'(rttb_pkg::DIV125_LO_RCP);
	assign floor_t32    = {fl_qhi_s4, fl_lo_prod[rttb_pkg::DIV125_LO_SHIFT +: 24]};
	assign ceil_us      = (cfg_floor_high_q < CapUs) ? cfg_floor_high_q : CapUs;
	assign floor_contra = (cfg_floor_low_q > ceil_us);

	// With a consistent configuration low <= ceiling <= FLOOR_CAP_US, so the
	// clamped target fits the applied-floor width.
	always_comb begin
		if (floor_t32 < 32'(cfg_floor_low_q))
			floor_tgt = FloorW'(cfg_floor_low_q);
		else if (floor_t32 > 32'(ceil_us))
			floor_tgt = FloorW'(ceil_us);
		else
			floor_tgt = FloorW'(floor_t32);
	end

	// ------------------------------------------------------------------
	// Stage 5: finished targets, ready to meet the per-flow state.
	// ------------------------------------------------------------------
	rttb_pkg::ctl_t    ctl_s5;
	logic [FloorW-1:0] floor_tgt_s5;
	logic              floor_contra_s5;
	logic [16:0]       capn_s5, capc_s5;
	logic              queue_s5;

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			ctl_s5          <= ctl_s4;
			floor_tgt_s5    <= floor_tgt;
			floor_contra_s5 <= floor_contra;
			capn_s5         <= capn_s4;
			capc_s5         <= capc_s4;
			queue_s5        <= queue_s4;
		end
	end

	// ------------------------------------------------------------------
	// Per-flow state and the decision logic.
	// ------------------------------------------------------------------
	logic [15:0]       sample_count_q, sample_count_d;
	logic [FloorW-1:0] applied_floor_q, applied_floor_d;
	logic [16:0]       applied_cap_q, applied_cap_d;
	logic [31:0]       last_ce_q, last_ce_d;

	logic               r_unsub, r_fw, r_cw, r_cong, r_skip;
	logic [FloorW-1:0]  r_fv;
	logic [16:0]        r_cv, cap_tgt;
	rttb_pkg::outcome_t r_fo, r_co;
	logic               ce_moved;

	assign ce_moved = (ctl_s5.ce != last_ce_q);
	assign cap_tgt  = (ce_moved || queue_s5) ? capc_s5 : capn_s5;

	always_comb begin
		r_unsub         = 1'b0;
		r_fw            = 1'b0;
		r_fv            = '0;
		r_fo            = rttb_pkg::OUT_NONE;
		r_cw            = 1'b0;
		r_cv            = 17'd0;
		r_co            = rttb_pkg::OUT_NONE;
		r_cong          = 1'b0;
		r_skip          = 1'b0;
		sample_count_d  = sample_count_q;
		applied_floor_d = applied_floor_q;
		applied_cap_d   = applied_cap_q;
		last_ce_d       = last_ce_q;

		if (!ctl_s5.func) begin
			sample_count_d  = 16'd0;
			applied_floor_d = '0;
			applied_cap_d   = 17'd0;
			last_ce_d       = 32'd0;
		end else if (!cfg_enable_q) begin
			r_unsub = 1'b1;
		end else if (ctl_s5.base_nz) begin
			if (sample_count_q < cfg_warmup_q) begin
				sample_count_d = sample_count_q + 16'd1;
				r_skip         = 1'b1;
			end else begin
				// Floor.
				if (floor_contra_s5) begin
					r_fo = rttb_pkg::OUT_CONTRADICTORY;
				end else if (applied_floor_q == floor_tgt_s5) begin
					r_fo = rttb_pkg::OUT_UNCHANGED;
				end else begin
					r_fw = 1'b1;
					r_fv = floor_tgt_s5;
					if (ctl_s5.floor_ok) begin
						applied_floor_d = floor_tgt_s5;
						r_fo            = rttb_pkg::OUT_APPLIED;
					end else begin
						r_fo = rttb_pkg::OUT_REJECTED;
					end
				end

				// Cap. The CE count is tracked even with cap tuning off.
				last_ce_d = ctl_s5.ce;
				if (cfg_cap_norm_q == 16'd0) begin
					if (applied_cap_q != 17'd0) begin
						r_cw = 1'b1;
						r_cv = rttb_pkg::CAP_MAX_MS;
						if (ctl_s5.cap_ok) begin
							applied_cap_d = 17'd0;
							r_co          = rttb_pkg::OUT_DEFAULT;
						end else begin
							r_co = rttb_pkg::OUT_REJECTED;
						end
					end
				end else begin
					r_cong = ce_moved || queue_s5;
					if (applied_cap_q == cap_tgt) begin
						r_co = rttb_pkg::OUT_UNCHANGED;
					end else begin
						r_cw = 1'b1;
						r_cv = cap_tgt;
						if (ctl_s5.cap_ok) begin
							applied_cap_d = cap_tgt;
							r_co          = rttb_pkg::OUT_APPLIED;
						end else begin
							r_co = rttb_pkg::OUT_REJECTED;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q  <= 16'd0;
			applied_floor_q <= '0;
			applied_cap_q   <= 17'd0;
			last_ce_q       <= 32'd0;
		end else if (retire) begin
			sample_count_q  <= sample_count_d;
			applied_floor_q <= applied_floor_d;
			applied_cap_q   <= applied_cap_d;
			last_ce_q       <= last_ce_d;
		end
	end

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	logic               unsub_q, fw_q, cw_q, cong_q, skip_q;
	logic [17:0]        fv_q;
	logic [16:0]        cv_q;
	rttb_pkg::outcome_t fo_q, co_q;

	always_ff @(posedge clk) begin
		if (ld_out) begin
			unsub_q <= r_unsub;
			fw_q    <= r_fw;
			fv_q    <= 18'(r_fv);
			fo_q    <= r_fo;
			cw_q    <= r_cw;
			cv_q    <= r_cv;
			co_q    <= r_co;
			cong_q  <= r_cong;
			skip_q  <= r_skip;
		end
	end

	assign unsubscribe    = unsub_q;
	assign floor_write    = fw_q;
	assign floor_value_us = fv_q;
	assign floor_outcome  = fo_q;
	assign cap_write      = cw_q;
	assign cap_value_ms   = cv_q;
	assign cap_outcome    = co_q;
	assign congested      = cong_q;
	assign warmup_skip    = skip_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_unsub_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && unsub_q |-> !fw_q && !cw_q && !skip_q && !cong_q)
		else $error("unsubscribe result carries other activity");

	a_floor_write_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fw_q |->
			(fo_q == rttb_pkg::OUT_APPLIED) || (fo_q == rttb_pkg::OUT_REJECTED))
		else $error("floor write without applied or rejected outcome");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!retire |=> $stable(sample_count_q) && $stable(applied_floor_q) &&
			$stable(applied_cap_q) && $stable(last_ce_q))
		else $error("flow state changed without a retiring sample");

	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		(applied_cap_q == 17'd0) ||
			((applied_cap_q >= rttb_pkg::CAP_MIN_MS) &&
			 (applied_cap_q <= rttb_pkg::CAP_MAX_MS)))
		else $error("applied cap outside its range");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && out_valid_q)
		else $error("input stalled with room in the pipeline");

endmodule
